[design/vcnp_pkg.sv]
// Shared types, widths and codes for the view-cone nearest-object picker.
package vcnp_pkg;

	localparam int COORD_W         = 20;
	localparam int MAG_W           = COORD_W + 1;
	localparam int FWD_W           = 16;
	localparam int RAD_W           = 20;
	localparam int COS_W           = 15;
	localparam int CFG_W           = 20;
	localparam int CFG_IDX_W       = 3;
	localparam int DOT_W           = COORD_W + 19;
	localparam int DOTM_W          = DOT_W - 1;
	localparam int HALF_W          = (DOTM_W + 1) / 2;
	localparam int DIST_W          = 2 * MAG_W + 2;
	localparam int MUL_W           = 2 * COS_W;
	localparam int PROD_W          = 2 * MUL_W;
	localparam int CMP_W           = 2 * DOTM_W;
	localparam int IDX_W           = 8;
	localparam int BDIST_W         = 2 * RAD_W;
	localparam int STEP_W          = 4;
	localparam int MAX_OBJECTS_DEF = 256;

	typedef struct packed {
		logic signed [COORD_W-1:0] obj_x;
		logic signed [COORD_W-1:0] obj_y;
		logic signed [COORD_W-1:0] obj_z;
		logic                      slot_used;
		logic                      last;
	} vcnp_obj_t;

	typedef struct packed {
		logic               found;
		logic [IDX_W-1:0]   best_index;
		logic [BDIST_W-1:0] best_dist_sq;
	} vcnp_res_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAM_X,
		REG_CAM_Y,
		REG_CAM_Z,
		REG_FWD_X,
		REG_FWD_Y,
		REG_FWD_Z,
		REG_RADIUS,
		REG_CONE_COS
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_DECIDE
	} state_t;

	// Multiplier schedule, issued in this order.
	typedef enum logic [STEP_W-1:0] {
		ST_DX,
		ST_DY,
		ST_DZ,
		ST_FX,
		ST_FY,
		ST_FZ,
		ST_RR,
		ST_CC,
		ST_LHH,
		ST_LHL,
		ST_LLL,
		ST_RLO,
		ST_RHI
	} step_t;

	typedef struct packed {
		logic  vld;
		step_t step;
	} vcnp_mtag_t;

endpackage

[design/vcnp_mul_unit.sv]
// Shared unsigned multiplier with a registered product and operation tag.
module vcnp_mul_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vcnp_pkg::vcnp_mtag_t        tag,
	input  logic [vcnp_pkg::MUL_W-1:0]  a,
	input  logic [vcnp_pkg::MUL_W-1:0]  b,
	output vcnp_pkg::vcnp_mtag_t        tag_s1,
	output logic [vcnp_pkg::PROD_W-1:0] prod_s1
);
	import vcnp_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk) begin
		if (tag.vld) begin
			prod_s1 <= PROD_W'(a) * PROD_W'(b);
		end
	end

endmodule

[design/view_cone_nearest_pick.sv]
// Top level: nearest used object inside the search radius and the view cone.
// One object at a time; the shared multiplier runs 13 products per object.
// A last object's result is registered onto res after the run, drain and decide states.
// Busy: obj_stall is high from the cycle after a transfer until the object is decided.
// Reset: config registers take their defaults, the running best is cleared, no result pending.
// Config writes are taken every cycle and must only happen while the block is idle.
module view_cone_nearest_pick #(
	parameter int MAX_OBJECTS = vcnp_pkg::MAX_OBJECTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           obj_valid,
	output logic                           obj_stall,
	input  vcnp_pkg::vcnp_obj_t            obj,
	output logic                           res_valid,
	input  logic                           res_stall,
	output vcnp_pkg::vcnp_res_t            res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [vcnp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vcnp_pkg::CFG_W-1:0]     cfg_data
);
	import vcnp_pkg::*;

	localparam int CNT_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic signed [COORD_W-1:0] cam_q [3];
	logic signed [FWD_W-1:0]   fwd_q [3];
	logic [RAD_W-1:0]          radius_q;
	logic [COS_W-1:0]          cos_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q[0] <= '0;
			cam_q[1] <= '0;
			cam_q[2] <= '0;
			fwd_q[0] <= '0;
			fwd_q[1] <= '0;
			fwd_q[2] <= FWD_W'(16384);
			radius_q <= RAD_W'(2560);
			cos_q    <= COS_W'(15565);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_CAM_X:    cam_q[0] <= cfg_data[COORD_W-1:0];
				REG_CAM_Y:    cam_q[1] <= cfg_data[COORD_W-1:0];
				REG_CAM_Z:    cam_q[2] <= cfg_data[COORD_W-1:0];
				REG_FWD_X:    fwd_q[0] <= cfg_data[FWD_W-1:0];
				REG_FWD_Y:    fwd_q[1] <= cfg_data[FWD_W-1:0];
				REG_FWD_Z:    fwd_q[2] <= cfg_data[FWD_W-1:0];
				REG_RADIUS:   radius_q <= cfg_data[RAD_W-1:0];
				REG_CONE_COS: cos_q    <= cfg_data[COS_W-1:0];
				default:      ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	state_t state_q, state_d;
	step_t  step_q;
	logic   obj_xfer;
	logic   issue;
	logic   decide_go;
	logic   res_xfer;
	logic   res_valid_q;
	logic   last_q;

	assign obj_xfer = obj_valid && !obj_stall;
	assign res_xfer = res_valid_q && !res_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (obj_xfer) state_d = S_RUN;
			S_RUN:    if (step_q == ST_RHI) state_d = S_DRAIN;
			S_DRAIN:  state_d = S_DECIDE;
			S_DECIDE: if (decide_go) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		obj_stall = (state_q != S_IDLE);
		issue     = (state_q == S_RUN);
		// hold the decision of a last object while the previous result is still waiting
		decide_go = (state_q == S_DECIDE) && !(last_q && res_valid_q && res_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_DX;
		end else begin
			state_q <= state_d;
			if (obj_xfer) begin
				step_q <= ST_DX;
			end else if (issue && step_q != ST_RHI) begin
				step_q <= step_t'(STEP_W'(step_q) + STEP_W'(1));
			end
		end
	end

	// ---------------------------------------------------------------
	// Object capture: offsets from the camera, split into sign and magnitude
	// ---------------------------------------------------------------
	logic signed [COORD_W-1:0] objc [3];
	logic signed [MAG_W-1:0]   diff [3];
	logic [MAG_W-1:0]          dmag [3];
	logic [FWD_W-1:0]          fmag [3];

	logic [MAG_W-1:0] mag_q  [3];
	logic             dsgn_q [3];
	logic [FWD_W-1:0] fmag_q [3];
	logic             fsgn_q [3];
	logic             used_q;

	assign objc[0] = obj.obj_x;
	assign objc[1] = obj.obj_y;
	assign objc[2] = obj.obj_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = MAG_W'(objc[i]) - MAG_W'(cam_q[i]);
			dmag[i] = diff[i][MAG_W-1] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
			fmag[i] = fwd_q[i][FWD_W-1] ? FWD_W'(-fwd_q[i]) : FWD_W'(fwd_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (obj_xfer) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i]  <= dmag[i];
				dsgn_q[i] <= diff[i][MAG_W-1];
				fmag_q[i] <= fmag[i];
				fsgn_q[i] <= fwd_q[i][FWD_W-1];
			end
			used_q <= obj.slot_used;
			last_q <= obj.last;
		end
	end

	// ---------------------------------------------------------------
	// Operand select for the shared multiplier
	// ---------------------------------------------------------------
	logic [DIST_W-1:0]  dist_q;
	logic [DOT_W-1:0]   dot_q;
	logic [BDIST_W-1:0] rr_q;
	logic [MUL_W-1:0]   c2_q;
	logic [CMP_W-1:0]   lhs_q;
	logic [CMP_W-1:0]   rhs_q;

	logic [MUL_W-1:0]    op_a;
	logic [MUL_W-1:0]    op_b;
	vcnp_mtag_t          mtag;
	vcnp_mtag_t          mtag_s1;
	logic [PROD_W-1:0]   prod_s1;

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (step_q)
			ST_DX:  begin op_a = MUL_W'(mag_q[0]); op_b = MUL_W'(mag_q[0]); end
			ST_DY:  begin op_a = MUL_W'(mag_q[1]); op_b = MUL_W'(mag_q[1]); end
			ST_DZ:  begin op_a = MUL_W'(mag_q[2]); op_b = MUL_W'(mag_q[2]); end
			ST_FX:  begin op_a = MUL_W'(fmag_q[0]); op_b = MUL_W'(mag_q[0]); end
			ST_FY:  begin op_a = MUL_W'(fmag_q[1]); op_b = MUL_W'(mag_q[1]); end
			ST_FZ:  begin op_a = MUL_W'(fmag_q[2]); op_b = MUL_W'(mag_q[2]); end
			ST_RR:  begin op_a = MUL_W'(radius_q); op_b = MUL_W'(radius_q); end
			ST_CC:  begin op_a = MUL_W'(cos_q); op_b = MUL_W'(cos_q); end
			// square of the dot product in halves; only meaningful when it is positive
			ST_LHH: begin
				op_a = MUL_W'(dot_q[DOTM_W-1:HALF_W]);
				op_b = MUL_W'(dot_q[DOTM_W-1:HALF_W]);
			end
			ST_LHL: begin
				op_a = MUL_W'(dot_q[DOTM_W-1:HALF_W]);
				op_b = MUL_W'(dot_q[HALF_W-1:0]);
			end
			ST_LLL: begin
				op_a = MUL_W'(dot_q[HALF_W-1:0]);
				op_b = MUL_W'(dot_q[HALF_W-1:0]);
			end
			// cosine squared times distance squared, in two halves of the distance
			ST_RLO: begin op_a = c2_q; op_b = MUL_W'(dist_q[RAD_W-1:0]); end
			ST_RHI: begin op_a = c2_q; op_b = MUL_W'(dist_q[BDIST_W-1:RAD_W]); end
			default: ;
		endcase
		mtag.vld  = issue;
		mtag.step = step_q;
	end

	vcnp_mul_unit u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag     (mtag),
		.a       (op_a),
		.b       (op_b),
		.tag_s1  (mtag_s1),
		.prod_s1 (prod_s1)
	);

	// ---------------------------------------------------------------
	// Accumulate the registered products
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (obj_xfer) begin
			dist_q <= '0;
			dot_q  <= '0;
			lhs_q  <= '0;
			rhs_q  <= '0;
		end else if (mtag_s1.vld) begin
			case (mtag_s1.step)
				ST_DX, ST_DY, ST_DZ: dist_q <= dist_q + prod_s1[DIST_W-1:0];
				ST_FX: dot_q <= (fsgn_q[0] ^ dsgn_q[0]) ? dot_q - prod_s1[DOT_W-1:0]
				                                        : dot_q + prod_s1[DOT_W-1:0];
				ST_FY: dot_q <= (fsgn_q[1] ^ dsgn_q[1]) ? dot_q - prod_s1[DOT_W-1:0]
				                                        : dot_q + prod_s1[DOT_W-1:0];
				ST_FZ: dot_q <= (fsgn_q[2] ^ dsgn_q[2]) ? dot_q - prod_s1[DOT_W-1:0]
				                                        : dot_q + prod_s1[DOT_W-1:0];
				ST_RR:  rr_q  <= prod_s1[BDIST_W-1:0];
				ST_CC:  c2_q  <= prod_s1[MUL_W-1:0];
				ST_LHH: lhs_q <= lhs_q + (CMP_W'(prod_s1) << (2 * HALF_W));
				ST_LHL: lhs_q <= lhs_q + (CMP_W'(prod_s1) << (HALF_W + 1));
				ST_LLL: lhs_q <= lhs_q + CMP_W'(prod_s1);
				ST_RLO: rhs_q <= rhs_q + CMP_W'(prod_s1);
				ST_RHI: rhs_q <= rhs_q + (CMP_W'(prod_s1) << RAD_W);
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Decide: candidate tests, running best, result register
	// ---------------------------------------------------------------
	logic               have_q;
	logic [CNT_W-1:0]   pos_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [BDIST_W-1:0] best_q;
	logic               cand;
	logic               take;
	logic               have_d;
	logic [CNT_W-1:0]   pos_d;
	logic [BDIST_W-1:0] best_d;
	vcnp_res_t          res_q;

	always_comb begin
		// unused slot, zero offset, outside the radius, behind the camera or outside the cone: drop
		cand = used_q && (dist_q != '0) && (dist_q <= DIST_W'(rr_q))
		    && !dot_q[DOT_W-1] && (dot_q != '0) && (lhs_q > rhs_q);
		// strict less-than keeps the earlier object on a tie
		take   = cand && (!have_q || dist_q[BDIST_W-1:0] < best_q);
		have_d = have_q || take;
		pos_d  = take ? cnt_q : pos_q;
		best_d = take ? dist_q[BDIST_W-1:0] : best_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			pos_q       <= '0;
			cnt_q       <= '0;
			best_q      <= '1;
			res_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one that transfers at this edge
			if (decide_go && last_q) begin
				res_valid_q <= 1'b1;
			end else if (res_xfer) begin
				res_valid_q <= 1'b0;
			end
			if (decide_go) begin
				if (last_q) begin
					have_q <= 1'b0;
					pos_q  <= '0;
					cnt_q  <= '0;
					best_q <= '1;
				end else begin
					have_q <= have_d;
					pos_q  <= pos_d;
					best_q <= best_d;
					cnt_q  <= (cnt_q == CNT_W'(MAX_OBJECTS - 1)) ? '0 : cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (decide_go && last_q) begin
			res_q.found        <= have_d;
			res_q.best_index   <= have_d ? IDX_W'(pos_d) : '0;
			res_q.best_dist_sq <= have_d ? best_d : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[design/vcnp_checker.sv]
// Port-level checks for the view-cone picker, bound to the top level.
module vcnp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                obj_valid,
	input logic                obj_stall,
	input logic                res_valid,
	input logic                res_stall,
	input vcnp_pkg::vcnp_res_t res
);
	import vcnp_pkg::*;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed or dropped while stalled");

	// one object at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		obj_valid && !obj_stall |=> obj_stall)
		else $error("object taken while the previous one is in work");

	// an empty result reports zero index and distance
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.found |-> res.best_index == '0 && res.best_dist_sq == '0)
		else $error("empty result carries a nonzero field");

	// a result never appears the cycle after an object transfer
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		obj_valid && !obj_stall |=> !$rose(res_valid))
		else $error("result appeared too early");

endmodule

bind view_cone_nearest_pick vcnp_checker u_vcnp_checker (.*);
